FILE: hdl/npe_pkg.sv
// Package for the negacyclic pair energy block.
// Holds ring and width constants, register indexes and the lane and enable types.
// No dependencies; every other file in hdl/ refers to it by scoped names.
package npe_pkg;

  localparam int POINTS     = 6;
  localparam int RING_SIZE  = 128;
  localparam int HALF_RING  = RING_SIZE / 2;
  localparam int POS_W      = 7;
  localparam int COEF_W     = 3;
  localparam int DIST_W     = 6;
  localparam int PROD_W     = 2 * COEF_W;
  localparam int PAIRS      = POINTS * (POINTS - 1) / 2;
  localparam int HALF_PAIRS = (PAIRS + 1) / 2;
  localparam int PART_W     = 9;
  localparam int TERM_W     = PROD_W + PART_W;
  localparam int HSUM_W     = 18;
  localparam int TOTAL_W    = 17;
  localparam int ENERGY_W   = 12;
  localparam int CFG_IDX_W  = 2;

  localparam logic [ENERGY_W-1:0] ENERGY_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HIGH = 2'd1;

  localparam logic [ENERGY_W-1:0] WINDOW_LOW_RST  = 12'd5;
  localparam logic [ENERGY_W-1:0] WINDOW_HIGH_RST = 12'd53;

  // What one pair lane reports: folded distance, signed product, and whether
  // the pair lands in a bucket at all (pairs half a ring apart do not).
  typedef struct packed {
    logic                     hit;
    logic [DIST_W-1:0]        span;
    logic signed [PROD_W-1:0] prod;
  } lane_t;

  // Load enables of the merge stages.
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
  } stage_en_t;

endpackage

FILE: hdl/npe_pair_lane.sv
// One pair lane: folds the distance of two ring positions and forms the
// signed coefficient product, negated when the distance wraps past half the ring.
// Depends on npe_pkg.
module npe_pair_lane (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic [npe_pkg::POS_W-1:0]         pos_p_i,
  input  logic [npe_pkg::POS_W-1:0]         pos_q_i,
  input  logic signed [npe_pkg::COEF_W-1:0] coef_p_i,
  input  logic signed [npe_pkg::COEF_W-1:0] coef_q_i,
  output npe_pkg::lane_t                    lane_o
);

  logic [npe_pkg::POS_W-1:0]         diff;
  logic [npe_pkg::POS_W:0]           wrapped;
  logic signed [npe_pkg::PROD_W-1:0] coef_p_ext;
  logic signed [npe_pkg::PROD_W-1:0] coef_q_ext;
  logic signed [npe_pkg::PROD_W-1:0] prod;
  npe_pkg::lane_t                    lane_d;
  npe_pkg::lane_t                    lane_q;

  always_comb begin
    diff       = (pos_q_i >= pos_p_i) ? (pos_q_i - pos_p_i) : (pos_p_i - pos_q_i);
    wrapped    = (npe_pkg::POS_W+1)'(npe_pkg::RING_SIZE) - {1'b0, diff};
    coef_p_ext = {{(npe_pkg::PROD_W-npe_pkg::COEF_W){coef_p_i[npe_pkg::COEF_W-1]}}, coef_p_i};
    coef_q_ext = {{(npe_pkg::PROD_W-npe_pkg::COEF_W){coef_q_i[npe_pkg::COEF_W-1]}}, coef_q_i};
    prod       = coef_p_ext * coef_q_ext;

    lane_d.hit = (diff != npe_pkg::POS_W'(npe_pkg::HALF_RING));
    if (diff > npe_pkg::POS_W'(npe_pkg::HALF_RING)) begin
      lane_d.span = wrapped[npe_pkg::DIST_W-1:0];
      lane_d.prod = -prod;
    end else begin
      lane_d.span = diff[npe_pkg::DIST_W-1:0];
      lane_d.prod = prod;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign lane_o = lane_q;

endmodule

FILE: hdl/npe_merge.sv
// Merge stages: per-lane bucket sums, per-lane energy terms, and two half sums.
// The energy equals the sum over lanes of prod times the sum of its bucket.
// Depends on npe_pkg.
module npe_merge (
  input  logic                              clk_i,
  input  npe_pkg::stage_en_t                en_i,
  input  npe_pkg::lane_t                    lanes_i [npe_pkg::PAIRS],
  output logic signed [npe_pkg::HSUM_W-1:0] half_lo_o,
  output logic signed [npe_pkg::HSUM_W-1:0] half_hi_o
);

  logic signed [npe_pkg::PART_W-1:0] part_lo_d [npe_pkg::PAIRS];
  logic signed [npe_pkg::PART_W-1:0] part_hi_d [npe_pkg::PAIRS];
  logic signed [npe_pkg::PROD_W-1:0] prodm_d   [npe_pkg::PAIRS];
  logic signed [npe_pkg::PART_W-1:0] part_lo_q [npe_pkg::PAIRS];
  logic signed [npe_pkg::PART_W-1:0] part_hi_q [npe_pkg::PAIRS];
  logic signed [npe_pkg::PROD_W-1:0] prodm_q   [npe_pkg::PAIRS];
  logic signed [npe_pkg::PART_W-1:0] bucket_sum [npe_pkg::PAIRS];
  logic signed [npe_pkg::TERM_W-1:0] term_d    [npe_pkg::PAIRS];
  logic signed [npe_pkg::TERM_W-1:0] term_q    [npe_pkg::PAIRS];
  logic signed [npe_pkg::HSUM_W-1:0] half_lo_d;
  logic signed [npe_pkg::HSUM_W-1:0] half_hi_d;
  logic signed [npe_pkg::HSUM_W-1:0] half_lo_q;
  logic signed [npe_pkg::HSUM_W-1:0] half_hi_q;

  // Bucket sum of each lane, split in two partial sums of at most eight terms.
  always_comb begin
    for (int p = 0; p < npe_pkg::PAIRS; p++) begin
      part_lo_d[p] = '0;
      part_hi_d[p] = '0;
      for (int q = 0; q < npe_pkg::PAIRS; q++) begin
        if (lanes_i[q].hit && (lanes_i[q].span == lanes_i[p].span)) begin
          if (q < npe_pkg::HALF_PAIRS) begin
            part_lo_d[p] = part_lo_d[p] + {{(npe_pkg::PART_W-npe_pkg::PROD_W)
                           {lanes_i[q].prod[npe_pkg::PROD_W-1]}}, lanes_i[q].prod};
          end else begin
            part_hi_d[p] = part_hi_d[p] + {{(npe_pkg::PART_W-npe_pkg::PROD_W)
                           {lanes_i[q].prod[npe_pkg::PROD_W-1]}}, lanes_i[q].prod};
          end
        end
      end
      prodm_d[p] = lanes_i[p].hit ? lanes_i[p].prod : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      part_lo_q <= part_lo_d;
      part_hi_q <= part_hi_d;
      prodm_q   <= prodm_d;
    end
  end

  // One small multiply per lane: own product times its bucket sum.
  always_comb begin
    for (int p = 0; p < npe_pkg::PAIRS; p++) begin
      bucket_sum[p] = part_lo_q[p] + part_hi_q[p];
      term_d[p] = {{(npe_pkg::TERM_W-npe_pkg::PROD_W){prodm_q[p][npe_pkg::PROD_W-1]}},
                   prodm_q[p]}
                * {{(npe_pkg::TERM_W-npe_pkg::PART_W){bucket_sum[p][npe_pkg::PART_W-1]}},
                   bucket_sum[p]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      term_q <= term_d;
    end
  end

  always_comb begin
    half_lo_d = '0;
    half_hi_d = '0;
    for (int p = 0; p < npe_pkg::PAIRS; p++) begin
      if (p < npe_pkg::HALF_PAIRS) begin
        half_lo_d = half_lo_d + {{(npe_pkg::HSUM_W-npe_pkg::TERM_W)
                    {term_q[p][npe_pkg::TERM_W-1]}}, term_q[p]};
      end else begin
        half_hi_d = half_hi_d + {{(npe_pkg::HSUM_W-npe_pkg::TERM_W)
                    {term_q[p][npe_pkg::TERM_W-1]}}, term_q[p]};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s4) begin
      half_lo_q <= half_lo_d;
      half_hi_q <= half_hi_d;
    end
  end

  assign half_lo_o = half_lo_q;
  assign half_hi_o = half_hi_q;

endmodule

FILE: hdl/negacyclic_pair_energy.sv
// Top level of the negacyclic pair energy block: pair lanes, merge stages,
// output register and the two window registers. Depends on npe_pkg,
// npe_pair_lane and npe_merge.

// The block takes one item (six ring positions and six signed coefficients)
// per clock cycle while in_stall_o is low and returns one result per item,
// in order. Fifteen pair lanes, one per unordered pair of points, fold each
// distance and form the signed product in the first stage. The merge then
// sums, for every lane, the products of all lanes that share its bucket; the
// energy is the sum over lanes of the lane's own product times that bucket
// sum, which equals the sum of squared bucket values. These partial sums, the
// per-lane products and the final add occupy stages two to five. Every stage
// has its own valid bit and loads when it is empty or the stage after it is
// moving, so new items keep entering while a result waits in the output
// register, until all five stages are full. The flag is set when the energy
// lies between window_low and window_high, both inclusive, and is 1 modulo 4;
// the energy saturates at 4095. The window registers are written over the
// configuration port (index 0 low, index 1 high, other indexes ignored) and
// should only change while no item is in flight.
module negacyclic_pair_energy (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [npe_pkg::POS_W-1:0]           pos_a_i,
  input  logic [npe_pkg::POS_W-1:0]           pos_b_i,
  input  logic [npe_pkg::POS_W-1:0]           pos_c_i,
  input  logic [npe_pkg::POS_W-1:0]           pos_d_i,
  input  logic [npe_pkg::POS_W-1:0]           pos_e_i,
  input  logic [npe_pkg::POS_W-1:0]           pos_f_i,
  input  logic signed [npe_pkg::COEF_W-1:0]   coef_a_i,
  input  logic signed [npe_pkg::COEF_W-1:0]   coef_b_i,
  input  logic signed [npe_pkg::COEF_W-1:0]   coef_c_i,
  input  logic signed [npe_pkg::COEF_W-1:0]   coef_d_i,
  input  logic signed [npe_pkg::COEF_W-1:0]   coef_e_i,
  input  logic signed [npe_pkg::COEF_W-1:0]   coef_f_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [npe_pkg::ENERGY_W-1:0]        energy_o,
  output logic                                in_window_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [npe_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [npe_pkg::ENERGY_W-1:0]        cfg_data_i
);

  localparam int STAGES = 5;

  logic [npe_pkg::POS_W-1:0]         pos  [npe_pkg::POINTS];
  logic signed [npe_pkg::COEF_W-1:0] coef [npe_pkg::POINTS];
  npe_pkg::lane_t                    lanes [npe_pkg::PAIRS];
  npe_pkg::stage_en_t                merge_en;

  logic [STAGES-1:0] valid_q;
  logic [STAGES-1:0] valid_d;
  logic [STAGES:0]   rdy;

  logic [npe_pkg::ENERGY_W-1:0] window_low_q;
  logic [npe_pkg::ENERGY_W-1:0] window_high_q;

  logic signed [npe_pkg::HSUM_W-1:0] half_lo;
  logic signed [npe_pkg::HSUM_W-1:0] half_hi;
  logic signed [npe_pkg::HSUM_W:0]   total_s;
  logic [npe_pkg::TOTAL_W-1:0]       total;
  logic [npe_pkg::ENERGY_W-1:0]      energy_d;
  logic [npe_pkg::ENERGY_W-1:0]      energy_q;
  logic                              in_window_d;
  logic                              in_window_q;

  assign pos  = '{pos_a_i, pos_b_i, pos_c_i, pos_d_i, pos_e_i, pos_f_i};
  assign coef = '{coef_a_i, coef_b_i, coef_c_i, coef_d_i, coef_e_i, coef_f_i};

  // A stage may load when it is empty or when the stage after it moves on.
  always_comb begin
    rdy[STAGES] = !out_stall_i;
    for (int k = STAGES - 1; k >= 0; k--) begin
      rdy[k] = !valid_q[k] || rdy[k+1];
    end
    if (rdy[0]) begin
      valid_d[0] = in_valid_i;
    end else begin
      valid_d[0] = valid_q[0];
    end
    for (int k = 1; k < STAGES; k++) begin
      if (rdy[k]) begin
        valid_d[k] = valid_q[k-1];
      end else begin
        valid_d[k] = valid_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_stall_o  = !rdy[0];
  assign merge_en.s2 = rdy[1];
  assign merge_en.s3 = rdy[2];
  assign merge_en.s4 = rdy[3];

  // One lane for each unordered pair of points, numbered row by row.
  for (genvar gi = 0; gi < npe_pkg::POINTS; gi++) begin : g_row
    for (genvar gj = gi + 1; gj < npe_pkg::POINTS; gj++) begin : g_col
      localparam int K = (gi * (2 * npe_pkg::POINTS - gi - 1)) / 2 + (gj - gi - 1);
      npe_pair_lane u_lane (
        .clk_i    (clk_i),
        .en_i     (rdy[0]),
        .pos_p_i  (pos[gi]),
        .pos_q_i  (pos[gj]),
        .coef_p_i (coef[gi]),
        .coef_q_i (coef[gj]),
        .lane_o   (lanes[K])
      );
    end
  end

  npe_merge u_merge (
    .clk_i     (clk_i),
    .en_i      (merge_en),
    .lanes_i   (lanes),
    .half_lo_o (half_lo),
    .half_hi_o (half_hi)
  );

  // Final add, saturation and window test. The total is a sum of squares, so
  // it is never negative and fits the unsigned width below.
  always_comb begin
    total_s     = {half_lo[npe_pkg::HSUM_W-1], half_lo} + {half_hi[npe_pkg::HSUM_W-1], half_hi};
    total       = total_s[npe_pkg::TOTAL_W-1:0];
    energy_d    = (total > npe_pkg::TOTAL_W'(npe_pkg::ENERGY_MAX)) ? npe_pkg::ENERGY_MAX
                                                                   : total[npe_pkg::ENERGY_W-1:0];
    in_window_d = (total >= npe_pkg::TOTAL_W'(window_low_q))
               && (total <= npe_pkg::TOTAL_W'(window_high_q))
               && (total[1:0] == 2'b01);
  end

  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      energy_q    <= energy_d;
      in_window_q <= in_window_d;
    end
  end

  assign out_valid_o = valid_q[STAGES-1];
  assign energy_o    = energy_q;
  assign in_window_o = in_window_q;

  // Configuration writes are always taken; unknown indexes are dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_low_q  <= npe_pkg::WINDOW_LOW_RST;
      window_high_q <= npe_pkg::WINDOW_HIGH_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        npe_pkg::REG_WINDOW_LOW: begin
          window_low_q <= cfg_data_i;
        end
        npe_pkg::REG_WINDOW_HIGH: begin
          window_high_q <= cfg_data_i;
        end
        default: begin
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // A flagged energy is always 1 modulo 4.
  a_flag_mod4 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && in_window_o) |-> (energy_o[1:0] == 2'b01))
    else $error("flagged energy is not 1 modulo 4");

  // Input is held off only when every stage holds an item.
  a_stall_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&valid_q))
    else $error("input stalled while the pipeline has room");

  // An accepted item occupies the first stage in the next cycle.
  a_accept_loads : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> valid_q[0])
    else $error("accepted item lost at the first stage");
`endif

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for negacyclic_pair_energy. It holds its own energy predictor
// and drives directed items, window register writes and random streams with random idling.
// Depends on npe_pkg and the negacyclic_pair_energy RTL.
module testbench;
  import npe_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LATENCY = 5;
  localparam int HOLD_CYCLES = 400;

  localparam logic [ENERGY_W-1:0] LOW_AFTER_RESET  = 12'd5;
  localparam logic [ENERGY_W-1:0] HIGH_AFTER_RESET = 12'd53;

  // Register indexes past the two window registers; writes there must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef struct packed {
    logic [POINTS-1:0][POS_W-1:0]  pos;
    logic [POINTS-1:0][COEF_W-1:0] coef;
  } ring_item_t;

  typedef struct packed {
    logic [ENERGY_W-1:0] energy;
    logic                in_window;
  } energy_result_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic [POS_W-1:0]         pos_a_i, pos_b_i, pos_c_i, pos_d_i, pos_e_i, pos_f_i;
  logic signed [COEF_W-1:0] coef_a_i, coef_b_i, coef_c_i, coef_d_i, coef_e_i, coef_f_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic [ENERGY_W-1:0]      energy_o;
  logic                     in_window_o;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic [CFG_IDX_W-1:0]     cfg_index_i;
  logic [ENERGY_W-1:0]      cfg_data_i;

  // Testbench copy of the window registers.
  logic [ENERGY_W-1:0] window_low_q;
  logic [ENERGY_W-1:0] window_high_q;

  energy_result_t energy_expect_q[$];
  energy_result_t want_r;

  int  fail_count;
  int  items_sent;
  int  results_seen;
  int  flagged_seen;
  int  reg_writes;
  int  idle_cycles;
  int  stall_left;
  bit  send_idle_on;
  bit  recv_idle_on;
  logic hold_active;

  negacyclic_pair_energy dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Bucket the signed pair products by folded distance and sum the squares.
  function automatic energy_result_t predict_energy(input ring_item_t it);
    int bucket[HALF_RING + 1];
    int span, prod, total, i, j;
    energy_result_t r;
    foreach (bucket[k]) bucket[k] = 0;
    for (i = 0; i < POINTS; i++) begin
      for (j = i + 1; j < POINTS; j++) begin
        span = int'(it.pos[j]) - int'(it.pos[i]);
        if (span < 0) span = -span;
        prod = int'($signed(it.coef[i])) * int'($signed(it.coef[j]));
        // Pairs exactly half a ring apart land in no bucket.
        if (span == HALF_RING) continue;
        // Distances past half the ring wrap around and flip the sign.
        if (span > HALF_RING) begin
          span = RING_SIZE - span;
          prod = -prod;
        end
        bucket[span] += prod;
      end
    end
    total = 0;
    foreach (bucket[k]) total += bucket[k] * bucket[k];
    r.energy = (total > int'(ENERGY_MAX)) ? ENERGY_MAX : total[ENERGY_W-1:0];
    // The flag is judged on the unsaturated sum.
    r.in_window = (total >= int'(window_low_q)) && (total <= int'(window_high_q))
                  && (total % 4 == 1);
    return r;
  endfunction

  // Random item: positions either spread, clustered, on a coarse grid or
  // paired across half the ring, so that buckets collide and fold often.
  function automatic ring_item_t random_item();
    ring_item_t it;
    int style, anchor, k, p, c;
    style  = $urandom_range(0, 3);
    anchor = $urandom_range(0, 127);
    for (k = 0; k < POINTS; k++) begin
      case (style)
        0: begin
          p = $urandom_range(0, 127);
        end
        1: begin
          p = anchor + $urandom_range(0, 7);
        end
        2: begin
          p = anchor + 16 * $urandom_range(0, 7);
        end
        default: begin
          p = anchor + 64 * $urandom_range(0, 1) + $urandom_range(0, 2);
        end
      endcase
      it.pos[k] = p[POS_W-1:0];
      // Mostly legal coefficients; now and then any 3-bit code, including -4, -3 and 3.
      if ($urandom_range(0, 9) < 8) c = int'($urandom_range(0, 4)) - 2;
      else c = $urandom_range(0, 7);
      it.coef[k] = c[COEF_W-1:0];
    end
    return it;
  endfunction

  // Offers one item and waits for its transfer; the prediction is queued at that edge.
  task automatic send_item(input ring_item_t it);
    int gap;
    gap = send_idle_on ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pos_a_i  <= it.pos[0];
    pos_b_i  <= it.pos[1];
    pos_c_i  <= it.pos[2];
    pos_d_i  <= it.pos[3];
    pos_e_i  <= it.pos[4];
    pos_f_i  <= it.pos[5];
    coef_a_i <= it.coef[0];
    coef_b_i <= it.coef[1];
    coef_c_i <= it.coef[2];
    coef_d_i <= it.coef[3];
    coef_e_i <= it.coef[4];
    coef_f_i <= it.coef[5];
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    energy_expect_q = {energy_expect_q, predict_energy(it)};
    items_sent++;
  endtask

  task automatic send_points(input int pa, pb, pc, pd, pe, pf, ca, cb, cc, cd, ce, cf);
    ring_item_t it;
    it.pos[0]  = pa[POS_W-1:0];
    it.pos[1]  = pb[POS_W-1:0];
    it.pos[2]  = pc[POS_W-1:0];
    it.pos[3]  = pd[POS_W-1:0];
    it.pos[4]  = pe[POS_W-1:0];
    it.pos[5]  = pf[POS_W-1:0];
    it.coef[0] = ca[COEF_W-1:0];
    it.coef[1] = cb[COEF_W-1:0];
    it.coef[2] = cc[COEF_W-1:0];
    it.coef[3] = cd[COEF_W-1:0];
    it.coef[4] = ce[COEF_W-1:0];
    it.coef[5] = cf[COEF_W-1:0];
    send_item(it);
  endtask

  // Stops offering items and waits until every queued result has come back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (energy_expect_q.size() != 0);
  endtask

  task automatic write_window_reg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [ENERGY_W-1:0] value);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
    if (idx == REG_WINDOW_LOW) window_low_q = value;
    else if (idx == REG_WINDOW_HIGH) window_high_q = value;
    reg_writes++;
  endtask

  task automatic set_window(input logic [ENERGY_W-1:0] low, input logic [ENERGY_W-1:0] high);
    write_window_reg(REG_WINDOW_LOW, low);
    write_window_reg(REG_WINDOW_HIGH, high);
  endtask

  // Field extremes, saturation, half-ring skips, folding and cancellation,
  // all under the window left by reset.
  task automatic test_directed_items();
    send_points(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_points(0, 0, 0, 0, 0, 0, 2, 2, 2, 2, 2, 2);
    send_points(127, 127, 127, 127, 127, 127, -2, -2, -2, -2, -2, -2);
    send_points(0, 0, 0, 0, 0, 0, -4, -4, -4, -4, -4, -4);
    send_points(127, 127, 127, 127, 127, 127, 3, 3, 3, 3, 3, 3);
    send_points(0, 64, 0, 64, 0, 64, 1, 1, 1, 1, 1, 1);
    send_points(0, 64, 9, 9, 9, 9, 2, 2, 0, 0, 0, 0);
    send_points(0, 100, 9, 9, 9, 9, 1, 1, 0, 0, 0, 0);
    send_points(127, 0, 9, 9, 9, 9, 1, -1, 0, 0, 0, 0);
    send_points(0, 65, 9, 9, 9, 9, 2, 2, 0, 0, 0, 0);
    send_points(0, 63, 9, 9, 9, 9, 1, 1, 0, 0, 0, 0);
    send_points(0, 10, 9, 9, 9, 9, 3, 1, 0, 0, 0, 0);
    send_points(5, 5, 5, 30, 30, 30, 1, 1, 1, 0, 0, 0);
    send_points(0, 10, 20, 9, 9, 9, 1, 1, -1, 0, 0, 0);
    send_points(0, 10, 118, 9, 9, 9, 1, 1, 1, 0, 0, 0);
    send_points(85, 42, 85, 42, 127, 0, -3, 3, -4, 1, -1, 2);
    send_points(0, 1, 2, 3, 4, 5, -1, -1, -1, -1, -1, -1);
    send_points(0, 21, 42, 63, 84, 105, -2, -1, 0, 1, 2, 3);
  endtask

  // Window extremes, empty and inverted windows, and writes to unused indexes.
  task automatic test_window_settings();
    logic [ENERGY_W-1:0] lows[10]  = '{12'd0, 12'd4095, 12'd0, 12'd4095, 12'd1,
                                       12'd9, 12'd0, 12'd53, 12'd100, 12'd5};
    logic [ENERGY_W-1:0] highs[10] = '{12'd4095, 12'd0, 12'd0, 12'd4095, 12'd1,
                                       12'd9, 12'd3600, 12'd5, 12'd2000, 12'd53};
    int s, n;
    for (s = 0; s < 10; s++) begin
      set_window(lows[s], highs[s]);
      if (s == 8) begin
        write_window_reg(REG_SPARE_A, 12'd0);
        write_window_reg(REG_SPARE_B, 12'd4095);
      end
      for (n = 0; n < 30; n++) send_item(random_item());
    end
  endtask

  // Long random stream; the window moves every block of items and idling is
  // switched off for some stretches.
  task automatic test_random_stream();
    int blk, n, low;
    for (blk = 0; blk < 8; blk++) begin
      low = $urandom_range(0, 200);
      if (blk == 3) set_window(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
      else set_window(low[ENERGY_W-1:0], 12'(low + $urandom_range(0, 400)));
      for (n = 0; n < 150; n++) begin
        if (n % 50 == 0) begin
          send_idle_on = ($urandom_range(0, 3) != 0);
          recv_idle_on = ($urandom_range(0, 3) != 0);
        end
        send_item(random_item());
      end
    end
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
  endtask

  // Back-to-back transfers on both channels.
  task automatic test_steady_flow();
    int n;
    set_window(LOW_AFTER_RESET, HIGH_AFTER_RESET);
    send_idle_on = 1'b0;
    recv_idle_on = 1'b0;
    for (n = 0; n < 200; n++) send_item(random_item());
  endtask

  // The receiver holds off for a long stretch while items keep coming, so the
  // pipeline fills and the input stalls; then everything drains in order.
  task automatic test_backpressure();
    int n;
    fork
      begin
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_active <= 1'b0;
      end
      for (n = 0; n < 120; n++) send_item(random_item());
    join
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
  endtask

  // Receiver side: after each result transfer, stall for a random number of cycles.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      stall_left = 0;
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
        stall_left = recv_idle_on ? $urandom_range(0, 8) : 0;
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall_i <= hold_active || (stall_left > 0);
    end
  end

  // Every result transfer is matched against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      results_seen++;
      if (energy_expect_q.size() == 0) begin
        $error("result with no item outstanding: energy %0d, in_window %0b",
               energy_o, in_window_o);
        fail_count++;
      end else begin
        want_r = energy_expect_q.pop_front();
        if (energy_o !== want_r.energy) begin
          $error("energy mismatch: expected %0d, got %0d", want_r.energy, energy_o);
          fail_count++;
        end
        if (in_window_o !== want_r.in_window) begin
          $error("in_window mismatch: expected %0b, got %0b", want_r.in_window, in_window_o);
          fail_count++;
        end
        if (want_r.in_window) flagged_seen++;
      end
    end
  end

  // Ends the run when no transfer of any kind has happened for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i === 1'b1 && in_stall_o === 1'b0)
        || (out_valid_o === 1'b1 && out_stall_i === 1'b0)
        || (cfg_valid_i === 1'b1 && cfg_ready_o === 1'b1)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("[negacyclic_pair_energy] ERROR");
      $finish;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    {pos_a_i, pos_b_i, pos_c_i, pos_d_i, pos_e_i, pos_f_i} = '0;
    {coef_a_i, coef_b_i, coef_c_i, coef_d_i, coef_e_i, coef_f_i} = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = REG_WINDOW_LOW;
    cfg_data_i    = '0;
    hold_active   = 1'b0;
    send_idle_on  = 1'b1;
    recv_idle_on  = 1'b1;
    window_low_q  = LOW_AFTER_RESET;
    window_high_q = HIGH_AFTER_RESET;
    fail_count    = 0;
    items_sent    = 0;
    results_seen  = 0;
    flagged_seen  = 0;
    reg_writes    = 0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed_items();
    test_window_settings();
    test_random_stream();
    test_steady_flow();
    test_backpressure();

    drain_results();
    repeat (4 * LATENCY) @(posedge clk_i);
    if (energy_expect_q.size() != 0) begin
      $error("%0d results never arrived", energy_expect_q.size());
      fail_count++;
    end

    $display("Sent %0d items and checked %0d results (%0d flagged) across %0d register writes.",
             items_sent, results_seen, flagged_seen, reg_writes);
    $display("Streams ran with random idling, steady flow and a %0d-cycle output hold-off.",
             HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("[negacyclic_pair_energy] OK");
    end else begin
      $display("[negacyclic_pair_energy] ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/npe_pkg.sv
hdl/npe_pair_lane.sv
hdl/npe_merge.sv
hdl/negacyclic_pair_energy.sv
tb/testbench.sv
